@@ hdl/mwe_pkg.sv @@
package mwe_pkg;

  localparam int unsigned ADDR_BITS_DEF = 6;
  localparam int unsigned DATA_BITS_DEF = 16;
  localparam int unsigned CMD_W         = 3;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_CMD_LO  = 4'd1,
    PH_CMD_HI  = 4'd2,
    PH_TAIL    = 4'd3,
    PH_RD_HI   = 4'd4,
    PH_RD_FALL = 4'd5,
    PH_WR_LO   = 4'd6,
    PH_WR_HI   = 4'd7,
    PH_DROP    = 4'd8,
    PH_BUSY    = 4'd9
  } phase_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_ERASE = 3'd3,
    CMD_EWEN  = 3'd4,
    CMD_EWDS  = 3'd5
  } cmd_e;

  // two-bit opcodes that follow the start bit
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_ERASE = 2'b11;
  localparam logic [1:0] OP_EXT   = 2'b00;

  typedef struct packed {
    logic chip_select;
    logic serial_clock;
    logic serial_data;
    logic ready;
    logic done;
  } pins_t;

endpackage

@@ hdl/mwe_seq.sv @@
module mwe_seq #(
  parameter int unsigned ADDR_BITS = mwe_pkg::ADDR_BITS_DEF,
  parameter int unsigned DATA_BITS = mwe_pkg::DATA_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [mwe_pkg::CMD_W-1:0]      command_i,
  input  logic [ADDR_BITS-1:0]           address_i,
  input  logic [DATA_BITS-1:0]           write_data_i,
  input  logic                           data_out_pin_i,
  output mwe_pkg::pins_t                 pins_o,
  output logic [DATA_BITS-1:0]           read_data_o
);

  localparam int unsigned FRAME_W = ADDR_BITS + 3;
  localparam int unsigned SHIFT_W = (DATA_BITS > FRAME_W) ? DATA_BITS : FRAME_W;
  localparam int unsigned CNT_W   = $clog2(SHIFT_W);

  mwe_pkg::phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]             bit_count_q, bit_count_d;
  logic [SHIFT_W-1:0]           shift_word_q, shift_word_d;
  logic [mwe_pkg::CMD_W-1:0]    command_latch_q, command_latch_d;
  logic [DATA_BITS-1:0]         read_acc_q, read_acc_d;
  logic [FRAME_W-1:0]           frame;
  logic [1:0]                   opcode;
  logic [ADDR_BITS-1:0]         frame_low;
  logic                         done;
  logic                         start;

  assign start = (command_i == mwe_pkg::CMD_READ) || (command_i == mwe_pkg::CMD_WRITE) ||
                 (command_i == mwe_pkg::CMD_ERASE) || (command_i == mwe_pkg::CMD_EWEN) ||
                 (command_i == mwe_pkg::CMD_EWDS);

  // start bit, opcode, then address (or extended-command pattern), MSB first
  always_comb begin
    opcode    = mwe_pkg::OP_EXT;
    frame_low = '0;
    case (command_i)
      mwe_pkg::CMD_READ: begin
        opcode    = mwe_pkg::OP_READ;
        frame_low = address_i;
      end
      mwe_pkg::CMD_WRITE: begin
        opcode    = mwe_pkg::OP_WRITE;
        frame_low = address_i;
      end
      mwe_pkg::CMD_ERASE: begin
        opcode    = mwe_pkg::OP_ERASE;
        frame_low = address_i;
      end
      mwe_pkg::CMD_EWEN: begin
        frame_low = {2'b11, {(ADDR_BITS-2){1'b0}}};
      end
      default: begin
        frame_low = '0;
      end
    endcase
    frame = {1'b1, opcode, frame_low};
  end

  always_comb begin
    phase_d         = phase_q;
    bit_count_d     = bit_count_q;
    shift_word_d    = shift_word_q;
    command_latch_d = command_latch_q;
    read_acc_d      = read_acc_q;
    done            = 1'b0;
    read_data_o     = '0;
    unique case (phase_q)
      mwe_pkg::PH_IDLE: begin
        if (start) begin
          command_latch_d = command_i;
          shift_word_d    = SHIFT_W'(frame);
          bit_count_d     = CNT_W'(ADDR_BITS + 2);
          if (command_i == mwe_pkg::CMD_READ) begin
            read_acc_d = '0;
          end
          phase_d = mwe_pkg::PH_CMD_LO;
        end
      end
      mwe_pkg::PH_CMD_LO: phase_d = mwe_pkg::PH_CMD_HI;
      mwe_pkg::PH_CMD_HI: begin
        if (bit_count_q != '0) begin
          bit_count_d = bit_count_q - 1'b1;
          phase_d     = mwe_pkg::PH_CMD_LO;
        end else if (command_latch_q == mwe_pkg::CMD_WRITE) begin
          shift_word_d = SHIFT_W'(write_data_i);
          bit_count_d  = CNT_W'(DATA_BITS - 1);
          phase_d      = mwe_pkg::PH_WR_LO;
        end else begin
          phase_d = mwe_pkg::PH_TAIL;
        end
      end
      mwe_pkg::PH_TAIL: begin
        if (command_latch_q == mwe_pkg::CMD_READ) begin
          bit_count_d = CNT_W'(DATA_BITS - 1);
          phase_d     = mwe_pkg::PH_RD_HI;
        end else if (command_latch_q == mwe_pkg::CMD_ERASE) begin
          phase_d = mwe_pkg::PH_DROP;
        end else begin
          done    = 1'b1;
          phase_d = mwe_pkg::PH_IDLE;
        end
      end
      mwe_pkg::PH_RD_HI: phase_d = mwe_pkg::PH_RD_FALL;
      mwe_pkg::PH_RD_FALL: begin
        // sample data-out one tick after the falling edge
        read_acc_d = read_acc_q | (DATA_BITS'(data_out_pin_i) << bit_count_q);
        if (bit_count_q != '0) begin
          bit_count_d = bit_count_q - 1'b1;
          phase_d     = mwe_pkg::PH_RD_HI;
        end else begin
          done        = 1'b1;
          read_data_o = read_acc_d;
          phase_d     = mwe_pkg::PH_IDLE;
        end
      end
      mwe_pkg::PH_WR_LO: phase_d = mwe_pkg::PH_WR_HI;
      mwe_pkg::PH_WR_HI: begin
        if (bit_count_q != '0) begin
          bit_count_d = bit_count_q - 1'b1;
          phase_d     = mwe_pkg::PH_WR_LO;
        end else begin
          phase_d = mwe_pkg::PH_DROP;
        end
      end
      mwe_pkg::PH_DROP: phase_d = mwe_pkg::PH_BUSY;
      mwe_pkg::PH_BUSY: begin
        if (data_out_pin_i) begin
          done    = 1'b1;
          phase_d = mwe_pkg::PH_IDLE;
        end
      end
      default: phase_d = mwe_pkg::PH_IDLE;
    endcase
  end

  // pin levels after this tick
  always_comb begin
    pins_o.chip_select  = (phase_d != mwe_pkg::PH_IDLE) && (phase_d != mwe_pkg::PH_DROP);
    pins_o.serial_clock = (phase_d == mwe_pkg::PH_CMD_HI) || (phase_d == mwe_pkg::PH_RD_HI) ||
                          (phase_d == mwe_pkg::PH_WR_HI);
    pins_o.serial_data  = 1'b0;
    if ((phase_d == mwe_pkg::PH_CMD_LO) || (phase_d == mwe_pkg::PH_CMD_HI) ||
        (phase_d == mwe_pkg::PH_WR_LO) || (phase_d == mwe_pkg::PH_WR_HI)) begin
      pins_o.serial_data = shift_word_d[bit_count_d];
    end
    pins_o.ready = (phase_d == mwe_pkg::PH_IDLE);
    pins_o.done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= mwe_pkg::PH_IDLE;
      bit_count_q     <= '0;
      shift_word_q    <= '0;
      command_latch_q <= '0;
      read_acc_q      <= '0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      bit_count_q     <= bit_count_d;
      shift_word_q    <= shift_word_d;
      command_latch_q <= command_latch_d;
      read_acc_q      <= read_acc_d;
    end
  end

endmodule

@@ hdl/mwe_out_reg.sv @@
module mwe_out_reg #(
  parameter int unsigned DATA_BITS = mwe_pkg::DATA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mwe_pkg::pins_t       pins_i,
  input  logic [DATA_BITS-1:0] read_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 busy_o,
  output mwe_pkg::pins_t       pins_o,
  output logic [DATA_BITS-1:0] read_data_o
);

  logic                 valid_q, valid_d;
  mwe_pkg::pins_t       pins_q;
  logic [DATA_BITS-1:0] read_data_q;

  // a waiting beat blocks the next load only while the sink stalls
  assign busy_o  = valid_q && out_stall_i;
  assign valid_d = load_i || busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pins_q      <= pins_i;
      read_data_q <= read_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign pins_o      = pins_q;
  assign read_data_o = read_data_q;

endmodule

@@ hdl/microwire_eeprom_master_core.sv @@
// channel | handshake              | payload
// --------+------------------------+---------------------------------------------
// in      | in_valid_i, in_stall_o | command_i address_i write_data_i
//         |                        | data_out_pin_i
// out     | out_valid_o,           | chip_select_o serial_clock_o serial_data_o
//         | out_stall_i            | ready_res_o done_res_o read_data_o
//
// One tick per clock: the sequencer state advances on the accepting edge and
// the pin levels for that tick are loaded into the result register on that edge.
// Throughput is one tick per cycle while out_stall_i is low.
// in_stall_o rises only while a result beat waits under out_stall_i.
// Reset (rst_ni low, asynchronous) puts the sequencer in idle and empties the
// result register.
module microwire_eeprom_master_core #(
  parameter int unsigned ADDR_BITS = mwe_pkg::ADDR_BITS_DEF,
  parameter int unsigned DATA_BITS = mwe_pkg::DATA_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mwe_pkg::CMD_W-1:0] command_i,
  input  logic [ADDR_BITS-1:0]      address_i,
  input  logic [DATA_BITS-1:0]      write_data_i,
  input  logic                      data_out_pin_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      chip_select_o,
  output logic                      serial_clock_o,
  output logic                      serial_data_o,
  output logic                      ready_res_o,
  output logic                      done_res_o,
  output logic [DATA_BITS-1:0]      read_data_o
);

  logic                 step;
  logic                 busy;
  mwe_pkg::pins_t       seq_pins;
  mwe_pkg::pins_t       out_pins;
  logic [DATA_BITS-1:0] seq_read_data;

  assign in_stall_o = busy;
  assign step       = in_valid_i && !busy;

  mwe_seq #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .data_out_pin_i (data_out_pin_i),
    .pins_o         (seq_pins),
    .read_data_o    (seq_read_data)
  );

  mwe_out_reg #(
    .DATA_BITS (DATA_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .pins_i      (seq_pins),
    .read_data_i (seq_read_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (busy),
    .pins_o      (out_pins),
    .read_data_o (read_data_o)
  );

  assign chip_select_o  = out_pins.chip_select;
  assign serial_clock_o = out_pins.serial_clock;
  assign serial_data_o  = out_pins.serial_data;
  assign ready_res_o    = out_pins.ready;
  assign done_res_o     = out_pins.done;

endmodule

@@ hdl/mwe_checker.sv @@
module mwe_checker #(
  parameter int unsigned DATA_BITS = mwe_pkg::DATA_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 chip_select_o,
  input logic                 serial_clock_o,
  input logic                 serial_data_o,
  input logic                 ready_res_o,
  input logic                 done_res_o,
  input logic [DATA_BITS-1:0] read_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(done_res_o) && $stable(chip_select_o))
    else $error("stalled result beat changed");

  // every accepted tick yields a result beat
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick produced no result");

  // completion always returns the bus to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> ready_res_o && !chip_select_o)
    else $error("done without returning to idle");

  // idle pins are all low
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ready_res_o |-> !chip_select_o && !serial_clock_o && !serial_data_o)
    else $error("pins active while idle");

  // read word is shown only with done
  a_rdata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> read_data_o == '0)
    else $error("read data outside done beat");

endmodule

bind microwire_eeprom_master_core mwe_checker #(
  .DATA_BITS (DATA_BITS)
) u_mwe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .chip_select_o  (chip_select_o),
  .serial_clock_o (serial_clock_o),
  .serial_data_o  (serial_data_o),
  .ready_res_o    (ready_res_o),
  .done_res_o     (done_res_o),
  .read_data_o    (read_data_o)
);

@@ dv/microwire_eeprom_master_core_checker.sv @@
module microwire_eeprom_master_core_checker
  import mwe_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [DATA_BITS-1:0] write_data_i,
  input  logic                 data_out_pin_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 chip_select_i,
  input  logic                 serial_clock_i,
  input  logic                 serial_data_i,
  input  logic                 ready_res_i,
  input  logic                 done_res_i,
  input  logic [DATA_BITS-1:0] read_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pins_t                pins;
    logic [DATA_BITS-1:0] word;
  } tick_levels_t;

  // sequencer copy
  phase_e               mode_q     = PH_IDLE;
  logic [4:0]           bits_left  = '0;
  logic [15:0]          shifter    = '0;
  cmd_e                 active_cmd = CMD_TICK;
  logic [DATA_BITS-1:0] read_word  = '0;

  tick_levels_t levels_due[$];

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s got 0x%0h, predicted 0x%0h", $time, field, got, want);
    fail_count_o++;
  endtask

  // start bit, two opcode bits, then the address or the extended-op pattern
  function automatic logic [15:0] frame_for(cmd_e cmd, logic [ADDR_BITS-1:0] addr);
    logic [1:0]           op;
    logic [ADDR_BITS-1:0] low;
    low = addr;
    case (cmd)
      CMD_READ:  op = OP_READ;
      CMD_WRITE: op = OP_WRITE;
      CMD_ERASE: op = OP_ERASE;
      CMD_EWEN: begin
        op  = OP_EXT;
        low = {2'b11, {(ADDR_BITS-2){1'b0}}};
      end
      default: begin
        op  = OP_EXT;
        low = '0;
      end
    endcase
    return 16'({1'b1, op, low});
  endfunction

  function automatic tick_levels_t advance_master(logic [CMD_W-1:0] cmd,
                                                  logic [ADDR_BITS-1:0] addr,
                                                  logic [DATA_BITS-1:0] wdata,
                                                  logic pin);
    tick_levels_t r;
    r = '0;
    case (mode_q)
      PH_IDLE: begin
        if (cmd >= CMD_READ && cmd <= CMD_EWDS) begin
          active_cmd = cmd_e'(cmd);
          shifter    = frame_for(active_cmd, addr);
          bits_left  = 5'(ADDR_BITS + 2);
          if (active_cmd == CMD_READ) read_word = '0;
          mode_q = PH_CMD_LO;
        end
      end
      PH_CMD_LO: mode_q = PH_CMD_HI;
      PH_CMD_HI: begin
        if (bits_left > 0) begin
          bits_left = bits_left - 1'b1;
          mode_q    = PH_CMD_LO;
        end else if (active_cmd == CMD_WRITE) begin
          shifter   = 16'(wdata);
          bits_left = 5'(DATA_BITS - 1);
          mode_q    = PH_WR_LO;
        end else begin
          mode_q = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (active_cmd == CMD_READ) begin
          bits_left = 5'(DATA_BITS - 1);
          mode_q    = PH_RD_HI;
        end else if (active_cmd == CMD_ERASE) begin
          mode_q = PH_DROP;
        end else begin
          r.pins.done = 1'b1;
          mode_q      = PH_IDLE;
        end
      end
      PH_RD_HI: mode_q = PH_RD_FALL;
      PH_RD_FALL: begin
        if (bits_left < 16) read_word[bits_left[3:0]] = read_word[bits_left[3:0]] | pin;
        if (bits_left > 0 && bits_left < 16) begin
          bits_left = bits_left - 1'b1;
          mode_q    = PH_RD_HI;
        end else begin
          r.pins.done = 1'b1;
          r.word      = read_word;
          mode_q      = PH_IDLE;
        end
      end
      PH_WR_LO: mode_q = PH_WR_HI;
      PH_WR_HI: begin
        if (bits_left > 0 && bits_left < 16) begin
          bits_left = bits_left - 1'b1;
          mode_q    = PH_WR_LO;
        end else begin
          mode_q = PH_DROP;
        end
      end
      PH_DROP: mode_q = PH_BUSY;
      PH_BUSY: begin
        if (pin) begin
          r.pins.done = 1'b1;
          mode_q      = PH_IDLE;
        end
      end
      default: mode_q = PH_IDLE;
    endcase

    r.pins.chip_select  = (mode_q != PH_IDLE) && (mode_q != PH_DROP);
    r.pins.serial_clock = (mode_q == PH_CMD_HI) || (mode_q == PH_RD_HI) ||
                          (mode_q == PH_WR_HI);
    if ((mode_q == PH_CMD_LO) || (mode_q == PH_CMD_HI) ||
        (mode_q == PH_WR_LO) || (mode_q == PH_WR_HI))
      r.pins.serial_data = (bits_left > 15) ? 1'b0 : shifter[bits_left[3:0]];
    r.pins.ready = (mode_q == PH_IDLE);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_levels_t want;
    if (!rst_ni) begin
      mode_q     = PH_IDLE;
      bits_left  = '0;
      shifter    = '0;
      active_cmd = CMD_TICK;
      read_word  = '0;
      levels_due.delete();
      pending_o <= 0;
    end else begin
      // check the outgoing beat before the incoming one can queue anything
      if (out_valid_i && !out_stall_i) begin
        if (levels_due.size() == 0) begin
          report_mismatch("unpredicted result beat", 1, 0);
        end else begin
          want = levels_due.pop_front();
          if (chip_select_i !== want.pins.chip_select)
            report_mismatch("chip_select", chip_select_i, want.pins.chip_select);
          if (serial_clock_i !== want.pins.serial_clock)
            report_mismatch("serial_clock", serial_clock_i, want.pins.serial_clock);
          if (serial_data_i !== want.pins.serial_data)
            report_mismatch("serial_data", serial_data_i, want.pins.serial_data);
          if (ready_res_i !== want.pins.ready)
            report_mismatch("ready_res", ready_res_i, want.pins.ready);
          if (done_res_i !== want.pins.done)
            report_mismatch("done_res", done_res_i, want.pins.done);
          if (read_data_i !== want.word)
            report_mismatch("read_data", read_data_i, want.word);
        end
      end
      if (in_valid_i && !in_stall_i)
        levels_due.push_back(advance_master(command_i, address_i, write_data_i,
                                            data_out_pin_i));
      pending_o <= levels_due.size();
    end
  end

endmodule

@@ dv/microwire_eeprom_master_core_tb.sv @@
module microwire_eeprom_master_core_tb;
  import mwe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_BITS = ADDR_BITS_DEF;
  localparam int unsigned DATA_BITS = DATA_BITS_DEF;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // ticks per command, command tick included (READ_TICKS stops before the final
  // read tick); write and erase reach the ready poll on their last tick
  localparam int READ_TICKS  = 51;
  localparam int WRITE_TICKS = 53;
  localparam int ERASE_TICKS = 22;
  localparam int EXT_TICKS   = 20;

  localparam int RANDOM_TICKS = 900;
  localparam int LONG_HOLD    = 200;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum int {PIN_RANDOM, PIN_HIGH, PIN_LOW} pin_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i;
  logic [ADDR_BITS-1:0] address_i;
  logic [DATA_BITS-1:0] write_data_i;
  logic                 data_out_pin_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 chip_select_o;
  logic                 serial_clock_o;
  logic                 serial_data_o;
  logic                 ready_res_o;
  logic                 done_res_o;
  logic [DATA_BITS-1:0] read_data_o;

  int fail_count;
  int pending;
  int ticks_sent    = 0;
  int tx_max        = 10;
  int rx_max        = 10;
  bit long_hold_req = 1'b0;

  microwire_eeprom_master_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .data_out_pin_i (data_out_pin_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chip_select_o  (chip_select_o),
    .serial_clock_o (serial_clock_o),
    .serial_data_o  (serial_data_o),
    .ready_res_o    (ready_res_o),
    .done_res_o     (done_res_o),
    .read_data_o    (read_data_o)
  );

  microwire_eeprom_master_core_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .data_out_pin_i (data_out_pin_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chip_select_i  (chip_select_o),
    .serial_clock_i (serial_clock_o),
    .serial_data_i  (serial_data_o),
    .ready_res_i    (ready_res_o),
    .done_res_i     (done_res_o),
    .read_data_i    (read_data_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL microwire_eeprom_master_core");
    $finish;
  end

  // result side: stall for a drawn number of cycles after every beat taken
  initial begin : result_sink
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (long_hold_req) begin
          hold          = LONG_HOLD;
          long_hold_req = 1'b0;
        end else begin
          hold = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
        end
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                           input logic [DATA_BITS-1:0] wdata, input logic pin);
    int gap;
    gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    address_i      <= addr;
    write_data_i   <= wdata;
    data_out_pin_i <= pin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  // one command, then plain ticks (random codes if noisy) until done; write and
  // erase see the memory busy for busy_zeros polls before it reports ready
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                               input logic [DATA_BITS-1:0] wdata, input pin_mode_e pin_mode,
                               input int busy_zeros, input bit noisy, input int slack);
    int         span;
    int         total;
    bit         polls;
    logic       pin;
    logic [CMD_W-1:0] c;
    polls = 1'b0;
    case (cmd)
      CMD_READ:  span = READ_TICKS;
      CMD_WRITE: begin
        span  = WRITE_TICKS;
        polls = 1'b1;
      end
      CMD_ERASE: begin
        span  = ERASE_TICKS;
        polls = 1'b1;
      end
      default:   span = EXT_TICKS;
    endcase
    total = span + slack + (polls ? busy_zeros : 0);
    for (int i = 0; i < total; i++) begin
      if (i == 0)
        c = cmd;
      else
        c = noisy ? 3'($urandom_range(0, 7)) : CMD_TICK;
      if (polls && i >= span - 1)
        pin = (i - (span - 1)) >= busy_zeros;
      else if (pin_mode == PIN_HIGH)
        pin = 1'b1;
      else if (pin_mode == PIN_LOW)
        pin = 1'b0;
      else
        pin = 1'($urandom_range(0, 1));
      send_tick(c, addr, wdata, pin);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int        seq_no;
    int        random_end;
    int        pick;
    pin_mode_e mode;
    in_valid_i     <= 1'b0;
    command_i      <= CMD_TICK;
    address_i      <= '0;
    write_data_i   <= '0;
    data_out_pin_i <= 1'b0;
    rst_ni         <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every command, spare codes, commands while busy
    issue_command(CMD_READ, 6'h00, 16'h0000, PIN_HIGH, 0, 1'b0, 1);
    issue_command(CMD_READ, 6'h3F, 16'hFFFF, PIN_LOW, 0, 1'b0, 1);
    issue_command(CMD_WRITE, 6'h3F, 16'hFFFF, PIN_LOW, 12, 1'b0, 1);
    issue_command(CMD_WRITE, 6'h00, 16'h0000, PIN_HIGH, 0, 1'b0, 0);
    issue_command(CMD_ERASE, 6'h3F, 16'hFFFF, PIN_RANDOM, 7, 1'b0, 1);
    issue_command(CMD_ERASE, 6'h00, 16'h0000, PIN_HIGH, 0, 1'b0, 0);
    issue_command(CMD_EWEN, 6'h3F, 16'hFFFF, PIN_HIGH, 0, 1'b0, 1);
    issue_command(CMD_EWDS, 6'h3F, 16'hFFFF, PIN_LOW, 0, 1'b0, 1);
    send_tick(CMD_SPARE6, 6'h15, 16'h5A5A, 1'b1);
    send_tick(CMD_SPARE7, 6'h2A, 16'hA5A5, 1'b0);
    send_tick(CMD_TICK, 6'h3F, 16'hFFFF, 1'b1);
    issue_command(CMD_READ, 6'h2A, 16'hC3A5, PIN_RANDOM, 0, 1'b1, 2);
    issue_command(CMD_WRITE, 6'h15, 16'h3C5A, PIN_RANDOM, 4, 1'b1, 2);

    random_end = ticks_sent + RANDOM_TICKS;
    seq_no     = 0;
    while (ticks_sent < random_end) begin
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      if (seq_no % 15 == 2) long_hold_req = 1'b1;
      if (seq_no % 15 == 6) drain_results();
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        case ($urandom_range(0, 3))
          0:       mode = PIN_HIGH;
          1:       mode = PIN_LOW;
          default: mode = PIN_RANDOM;
        endcase
        issue_command(3'($urandom_range(CMD_READ, CMD_EWDS)), 6'($urandom),
                      16'($urandom), mode,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3),
                      $urandom_range(0, 5) == 0, $urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(10, 30))
          send_tick(3'($urandom_range(0, 7)), 6'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
      end
      seq_no++;
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS microwire_eeprom_master_core");
    else
      $display("FAIL microwire_eeprom_master_core");
    $finish;
  end

endmodule

@@ microwire_eeprom_master_core.f @@
hdl/mwe_pkg.sv
hdl/mwe_seq.sv
hdl/mwe_out_reg.sv
hdl/microwire_eeprom_master_core.sv
hdl/mwe_checker.sv
dv/microwire_eeprom_master_core_checker.sv
dv/microwire_eeprom_master_core_tb.sv
